>>> hw/rtl/qet_pkg.sv
// qet_pkg: shared types, constants and corner arithmetic for the quadtree lookup
// used by qet_cfg and quadtree_extent_to_tile; no dependencies
package qet_pkg;

    localparam int MAX_LEVEL  = 16;
    localparam int COORD_BITS = 32;
    localparam int LVL_W      = 5;
    localparam int IDX_W      = 16;
    localparam int BASE_W     = 31;
    localparam int ADDR_W     = 4;
    // corner numerators: origin * 2^L + index * base_side, plus headroom
    localparam int NUM_W      = COORD_BITS + BASE_W + 2;

    typedef enum logic [1:0] {
        REG_ORIGIN_X  = 2'd0,
        REG_ORIGIN_Y  = 2'd1,
        REG_BASE_SIDE = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] ext_left;
        logic signed [31:0] ext_top;
        logic signed [31:0] ext_right;
        logic signed [31:0] ext_bottom;
    } in_word_t;

    typedef struct packed {
        logic [15:0] tile_col;
        logic [15:0] tile_row;
        logic [4:0]  tile_level;
        logic        depth_limited;
    } out_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] l;
        logic signed [NUM_W-1:0] t;
        logic signed [NUM_W-1:0] r;
        logic signed [NUM_W-1:0] b;
        logic signed [NUM_W-1:0] nx;
        logic signed [NUM_W-1:0] ny;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
        logic [LVL_W-1:0]        lvl;
        logic                    go;
    } stage_t;

    // numerator over 2^k, rounded toward zero (k is constant at each call site)
    function automatic logic signed [NUM_W-1:0] corner_f(
        input logic signed [NUM_W-1:0] n,
        input int                      k
    );
        logic signed [NUM_W-1:0] q;
        logic [NUM_W-1:0]        rem;
        q   = n >>> k;
        rem = n & ~({NUM_W{1'b1}} << k);
        if (n[NUM_W-1] && (rem != '0))
            q = q + NUM_W'(1);
        return q;
    endfunction

    function automatic logic signed [NUM_W-1:0] sext_f(input logic [COORD_BITS-1:0] v);
        return NUM_W'(signed'(v));
    endfunction

endpackage

>>> hw/rtl/quadtree_extent_to_tile.sv
// quadtree_extent_to_tile: deepest quadtree tile containing a query rectangle
// depends on qet_pkg and qet_cfg
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall   | in_word_t (four inclusive bounds)
//  out     | output    | out_valid/out_stall | out_word_t (col, row, level, limit flag)
//  cfg     | input     | apb, pready high    | origin_x, origin_y, base_side
//
// one input stage orders the bounds, then one
// stage per quadtree level tests the four children of the current tile.
// a new word can enter every cycle while in_stall is low.
// reset clears only the stage valid bits and the config registers; stage data is not reset.
// a stall on out while out_valid is high freezes every stage at once and is mirrored on in_stall.
module quadtree_extent_to_tile
    import qet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]       origin_x;
    logic [31:0]       origin_y;
    logic [BASE_W-1:0] base_side;

    qet_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .base_side (base_side)
    );

    stage_t                  st_reg   [0:MAX_LEVEL];
    stage_t                  st_next  [0:MAX_LEVEL];
    logic [MAX_LEVEL:0]      v_reg;
    logic                    adv;
    logic signed [NUM_W-1:0] base_n;

    // whole pipe moves unless the finished word is held at the output
    assign adv      = !(v_reg[MAX_LEVEL] && out_stall);
    assign in_stall = !adv;
    assign base_n   = NUM_W'({1'b0, base_side});

    // input stage: order the bounds, start at the root tile
    always_comb
    begin
        logic signed [NUM_W-1:0] l, t, r, b;
        l = sext_f(in_word.ext_left);
        t = sext_f(in_word.ext_top);
        r = sext_f(in_word.ext_right);
        b = sext_f(in_word.ext_bottom);
        st_next[0].l   = (r < l) ? r : l;
        st_next[0].r   = (r < l) ? l : r;
        st_next[0].t   = (b < t) ? b : t;
        st_next[0].b   = (b < t) ? t : b;
        st_next[0].nx  = sext_f(origin_x);
        st_next[0].ny  = sext_f(origin_y);
        st_next[0].col = '0;
        st_next[0].row = '0;
        st_next[0].lvl = '0;
        st_next[0].go  = 1'b1;
    end

    // one stage per level; numerators double each level so the child
    // corners are 2n, 2n + base and 2n + 2*base over 2^k
    genvar k;
    generate
        for (k = 1; k <= MAX_LEVEL; k++)
        begin : g_lvl
            always_comb
            begin
                logic signed [NUM_W-1:0] ex, ey, x0, xm, x1, y0, ym, y1;
                logic fxe, fxo, fye, fyo;
                logic dx, dy, hit;
                ex  = st_reg[k-1].nx <<< 1;
                ey  = st_reg[k-1].ny <<< 1;
                x0  = corner_f(ex, k);
                xm  = corner_f(ex + base_n, k);
                x1  = corner_f(ex + (base_n <<< 1), k);
                y0  = corner_f(ey, k);
                ym  = corner_f(ey + base_n, k);
                y1  = corner_f(ey + (base_n <<< 1), k);
                fxe = (x0 <= st_reg[k-1].l) && (st_reg[k-1].r <= xm);
                fxo = (xm <= st_reg[k-1].l) && (st_reg[k-1].r <= x1);
                fye = (y0 <= st_reg[k-1].t) && (st_reg[k-1].b <= ym);
                fyo = (ym <= st_reg[k-1].t) && (st_reg[k-1].b <= y1);
                // child order: (even,even), (odd,even), (odd,odd), (even,odd)
                dx  = 1'b0;
                dy  = 1'b0;
                hit = 1'b1;
                if (fxe && fye)
                begin
                    dx = 1'b0;
                    dy = 1'b0;
                end
                else if (fxo && fye)
                begin
                    dx = 1'b1;
                    dy = 1'b0;
                end
                else if (fxo && fyo)
                begin
                    dx = 1'b1;
                    dy = 1'b1;
                end
                else if (fxe && fyo)
                begin
                    dx = 1'b0;
                    dy = 1'b1;
                end
                else
                    hit = 1'b0;

                st_next[k] = st_reg[k-1];
                if (st_reg[k-1].go && hit)
                begin
                    st_next[k].nx  = dx ? (ex + base_n) : ex;
                    st_next[k].ny  = dy ? (ey + base_n) : ey;
                    st_next[k].col = {st_reg[k-1].col[IDX_W-2:0], dx};
                    st_next[k].row = {st_reg[k-1].row[IDX_W-2:0], dy};
                    st_next[k].lvl = st_reg[k-1].lvl + LVL_W'(1);
                end
                else
                    st_next[k].go = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[MAX_LEVEL-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st_next[0];
            for (int i = 1; i <= MAX_LEVEL; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign out_valid              = v_reg[MAX_LEVEL];
    assign out_word.tile_col      = st_reg[MAX_LEVEL].col;
    assign out_word.tile_row      = st_reg[MAX_LEVEL].row;
    assign out_word.tile_level    = st_reg[MAX_LEVEL].lvl;
    assign out_word.depth_limited = (st_reg[MAX_LEVEL].lvl == LVL_W'(MAX_LEVEL));

endmodule

>>> hw/rtl/qet_cfg.sv
// qet_cfg: apb register file holding origin and root tile side
// depends on qet_pkg
module qet_cfg
    import qet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       origin_x,
    output logic [31:0]       origin_y,
    output logic [BASE_W-1:0] base_side
);

    logic [31:0]       origin_x_reg;
    logic [31:0]       origin_y_reg;
    logic [BASE_W-1:0] base_side_reg;
    reg_idx_t          idx;
    logic              wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            base_side_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_ORIGIN_X:  origin_x_reg  <= pwdata;
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata;
                REG_BASE_SIDE: base_side_reg <= pwdata[BASE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_ORIGIN_Y:  prdata = origin_y_reg;
            REG_BASE_SIDE: prdata = {1'b0, base_side_reg};
            default:       prdata = '0;
        endcase
    end

    assign origin_x  = origin_x_reg;
    assign origin_y  = origin_y_reg;
    assign base_side = base_side_reg;

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking regression for quadtree_extent_to_tile
// depends on qet_pkg and the quadtree_extent_to_tile rtl; drives words, apb config
// and random stalls, and checks every result word against its typed row or its own tile predictor
module testbench;
    import qet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 2 * (MAX_LEVEL + 1) + 8;
    localparam int  PHASE_ITEMS    = 272;
    localparam int  NUM_PHASES     = 6;
    localparam int  MAX_SHOWN      = 10;

    // one row of the directed table
    typedef struct {
        in_word_t  query;
        bit        typed;     // expected word given in the row
        out_word_t tile;
    } query_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic      pready;

    // shadow of the block's registers
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [BASE_W-1:0]  side;

    out_word_t tile_q[$];      // predicted tiles waiting for their result word
    int  words_in;
    int  words_out;
    int  mismatches;
    int  deep_hits;            // results that hit the level limit
    bit  calm;                 // no idling on either side
    bit  hold_req;             // ask the receiver for a long hold-off
    int  hold_left;

    quadtree_extent_to_tile u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // tile predictor
    // ---------------------------------------------------------------

    // corner idx of a level-lvl tile along one axis, rounded toward zero
    function automatic longint tile_corner(longint org, longint idx, int lvl);
        longint scale;
        scale = longint'(1) << lvl;
        return (org * scale + idx * longint'(side)) / scale;
    endfunction

    function automatic bit tile_covers(longint c, longint r, int lvl,
                                       longint l, longint t, longint rt, longint b);
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        x0 = tile_corner(longint'(org_x), c, lvl);
        x1 = tile_corner(longint'(org_x), c + 1, lvl);
        y0 = tile_corner(longint'(org_y), r, lvl);
        y1 = tile_corner(longint'(org_y), r + 1, lvl);
        return x0 <= l && rt <= x1 && y0 <= t && b <= y1;
    endfunction

    // descend from the root while one of the four children holds the rectangle
    function automatic out_word_t deepest_tile(in_word_t q);
        longint l;
        longint t;
        longint rt;
        longint b;
        longint swp;
        longint col;
        longint row;
        longint c;
        longint r;
        int     lvl;
        bit     found;
        out_word_t res;
        l  = longint'(q.ext_left);
        t  = longint'(q.ext_top);
        rt = longint'(q.ext_right);
        b  = longint'(q.ext_bottom);
        // reversed bounds are put in order first
        if (rt < l)
        begin
            swp = l; l = rt; rt = swp;
        end
        if (b < t)
        begin
            swp = t; t = b; b = swp;
        end
        col = 0;
        row = 0;
        lvl = 0;
        found = 1'b1;
        while (lvl < MAX_LEVEL && found)
        begin
            found = 1'b0;
            // child order: (even,even) (odd,even) (odd,odd) (even,odd)
            for (int k = 0; k < 4 && !found; k++)
            begin
                c = col * longint'(2) + ((k == 1 || k == 2) ? longint'(1) : longint'(0));
                r = row * longint'(2) + ((k >= 2) ? longint'(1) : longint'(0));
                if (tile_covers(c, r, lvl + 1, l, t, rt, b))
                begin
                    col = c;
                    row = r;
                    lvl++;
                    found = 1'b1;
                end
            end
        end
        res.tile_col      = col[15:0];
        res.tile_row      = row[15:0];
        res.tile_level    = lvl[4:0];
        res.depth_limited = (lvl >= MAX_LEVEL);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // error reporting
    // ---------------------------------------------------------------
    task automatic flag_error(string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // apb register access, setup then access cycle
    // ---------------------------------------------------------------
    task automatic reg_write(reg_idx_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // unknown index is dropped by the block, so the shadow skips it too
        case (idx)
            REG_ORIGIN_X:  org_x = data;
            REG_ORIGIN_Y:  org_y = data;
            REG_BASE_SIDE: side  = data[BASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reg_check(reg_idx_t idx, logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_error($sformatf("reg %s read %h expected %h", idx.name(), got, want));
    endtask

    task automatic load_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] bs);
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_BASE_SIDE, bs);
        reg_write(REG_NONE, $urandom);
        reg_check(REG_ORIGIN_X, org_x);
        reg_check(REG_ORIGIN_Y, org_y);
        reg_check(REG_BASE_SIDE, {1'b0, side});
    endtask

    // ---------------------------------------------------------------
    // sender: random gaps, one assignment of in_valid per edge
    // ---------------------------------------------------------------
    task automatic send_query(in_word_t q, bit typed, out_word_t tile);
        bit taken;
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= q;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        tile_q.push_back(typed ? tile : deepest_tile(q));
        words_in++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        wait (tile_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // random rectangles, mostly inside a chosen tile so descent goes deep
    // ---------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint span;
        if (hi <= lo)
            return lo;
        span = hi - lo + 1;
        // short spans now and then make point-like rectangles
        if ($urandom_range(0, 3) == 0 && span > 4)
            span = 4;
        return lo + longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span;
    endfunction

    function automatic in_word_t random_query();
        in_word_t q;
        int       lvl;
        longint   c;
        longint   r;
        longint   x0;
        longint   x1;
        longint   y0;
        longint   y1;
        longint   l;
        longint   t;
        longint   swp;
        if ($urandom_range(0, 99) < 15)
        begin
            // noise over the whole field range, bounds in any order
            q.ext_left   = $urandom;
            q.ext_top    = $urandom;
            q.ext_right  = $urandom;
            q.ext_bottom = $urandom;
            return q;
        end
        lvl = $urandom_range(0, MAX_LEVEL);
        c   = longint'($urandom_range(0, (1 << lvl) - 1));
        r   = longint'($urandom_range(0, (1 << lvl) - 1));
        x0  = clamp32(tile_corner(longint'(org_x), c, lvl));
        x1  = clamp32(tile_corner(longint'(org_x), c + 1, lvl));
        y0  = clamp32(tile_corner(longint'(org_y), r, lvl));
        y1  = clamp32(tile_corner(longint'(org_y), r + 1, lvl));
        // now and then stretch past the tile edge
        if ($urandom_range(0, 9) == 0)
            x1 = clamp32(x1 + longint'($urandom_range(1, 3)));
        if ($urandom_range(0, 9) == 0)
            y0 = clamp32(y0 - longint'($urandom_range(1, 3)));
        l = pick_between(x0, x1);
        t = pick_between(y0, y1);
        q.ext_left   = 32'(l);
        q.ext_top    = 32'(t);
        q.ext_right  = 32'(pick_between(l, x1));
        q.ext_bottom = 32'(pick_between(t, y1));
        if ($urandom_range(0, 9) == 0)
        begin
            swp = longint'(q.ext_left); q.ext_left = q.ext_right; q.ext_right = 32'(swp);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            swp = longint'(q.ext_top); q.ext_top = q.ext_bottom; q.ext_bottom = 32'(swp);
        end
        return q;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stall, long hold-off on request, result checks
    // ---------------------------------------------------------------
    initial
    begin
        bit        take;
        out_word_t got;
        out_word_t want;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            take = out_valid && !out_stall;
            got  = out_word;
            @(posedge clk);
            if (take)
            begin
                words_out++;
                if (tile_q.size() == 0)
                    flag_error($sformatf("result word %p with nothing pending", got));
                else
                begin
                    want = tile_q.pop_front();
                    if (got.tile_col !== want.tile_col)
                        flag_error($sformatf("tile_col %0d expected %0d",
                                             got.tile_col, want.tile_col));
                    if (got.tile_row !== want.tile_row)
                        flag_error($sformatf("tile_row %0d expected %0d",
                                             got.tile_row, want.tile_row));
                    if (got.tile_level !== want.tile_level)
                        flag_error($sformatf("tile_level %0d expected %0d",
                                             got.tile_level, want.tile_level));
                    if (got.depth_limited !== want.depth_limited)
                        flag_error($sformatf("depth_limited %0b expected %0b",
                                             got.depth_limited, want.depth_limited));
                    if (want.depth_limited)
                        deep_hits++;
                end
            end
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 34);
        end
    end

    // watchdog: cycles with no word moving on either channel and no apb access
    initial
    begin
        int quiet;
        int seen;
        quiet = 0;
        seen  = 0;
        forever
        begin
            @(posedge clk);
            if (words_in + words_out != seen || psel)
            begin
                seen  = words_in + words_out;
                quiet = 0;
            end
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", quiet);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        query_row_t at_reset[$];
        query_row_t shaped[$];
        query_row_t row;
        logic [31:0] set_ox[NUM_PHASES];
        logic [31:0] set_oy[NUM_PHASES];
        logic [31:0] set_bs[NUM_PHASES];

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        org_x    = '0;
        org_y    = '0;
        side     = '0;
        words_in = 0;
        words_out = 0;
        mismatches = 0;
        deep_hits = 0;
        calm     = 1'b0;
        hold_req = 1'b0;

        // registers at reset: zero side, every tile collapses onto the origin
        at_reset.push_back('{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
                             '{16'd0, 16'd0, 5'd16, 1'b1}});
        at_reset.push_back('{'{32'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b1,
                             '{16'd0, 16'd0, 5'd0, 1'b0}});
        at_reset.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
                             1'b1, '{16'd0, 16'd0, 5'd0, 1'b0}});
        at_reset.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                             1'b1, '{16'd0, 16'd0, 5'd0, 1'b0}});
        at_reset.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                             1'b1, '{16'd0, 16'd0, 5'd0, 1'b0}});
        // reversed bounds span -1..0, which no child holds, so the result stays at the root
        at_reset.push_back('{'{32'sd0, 32'sd0, -32'sd1, -32'sd1}, 1'b1,
                             '{16'd0, 16'd0, 5'd0, 1'b0}});

        // root of side 65536 at the origin: each child in turn, straddles, outside
        shaped.push_back('{'{32'sd5, 32'sd5, 32'sd5, 32'sd5}, 1'b0, '0});
        shaped.push_back('{'{32'sd40000, 32'sd100, 32'sd40001, 32'sd101}, 1'b0, '0});
        shaped.push_back('{'{32'sd40000, 32'sd40000, 32'sd40010, 32'sd40010}, 1'b0, '0});
        shaped.push_back('{'{32'sd100, 32'sd40000, 32'sd101, 32'sd40001}, 1'b0, '0});
        shaped.push_back('{'{32'sd32767, 32'sd0, 32'sd32769, 32'sd5}, 1'b0, '0});
        shaped.push_back('{'{32'sd0, 32'sd0, 32'sd65536, 32'sd65536}, 1'b0, '0});
        shaped.push_back('{'{-32'sd5, 32'sd0, 32'sd3, 32'sd3}, 1'b0, '0});
        shaped.push_back('{'{32'sd65535, 32'sd65535, 32'sd65536, 32'sd65536}, 1'b0, '0});
        shaped.push_back('{'{32'sd200, 32'sd300, 32'sd10, 32'sd20}, 1'b0, '0});
        shaped.push_back('{'{32'sd70000, 32'sd5, 32'sd70000, 32'sd5}, 1'b0, '0});
        shaped.push_back('{'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
                           1'b0, '0});
        shaped.push_back('{'{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536}, 1'b0, '0});

        // settings walked by the random phases, extremes among them
        set_ox = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, -32'sd1000, 32'd0, $urandom};
        set_oy = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd500, 32'd0, $urandom};
        set_bs = '{32'd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd0,
                   $urandom_range(1, 32'h7fff_ffff)};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words against the reset registers
        foreach (at_reset[i])
        begin
            row = at_reset[i];
            send_query(row.query, row.typed, row.tile);
        end
        drain_results();

        load_setting(32'd0, 32'd0, 32'd65536);
        foreach (shaped[i])
        begin
            row = shaped[i];
            send_query(row.query, row.typed, row.tile);
        end
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_setting(set_ox[ph], set_oy[ph], set_bs[ph]);
            // second phase fills the pipeline behind a long receiver hold-off
            hold_req = (ph == 1);
            // third phase runs with no idling on either side
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // fourth phase: sender stops midway until every result is back
                if (ph == 3 && n == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    wait (tile_q.size() == 0);
                    @(posedge clk);
                end
                send_query(random_query(), 1'b0, '0);
            end
            drain_results();
            calm = 1'b0;
        end

        $display("covered %0d query words, %0d result words over %0d register settings",
                 words_in, words_out, NUM_PHASES + 1);
        $display("%0d results hit the level limit, %0d mismatches", deep_hits, mismatches);
        if (mismatches == 0 && tile_q.size() == 0 && words_in == words_out)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
